// ===== rtl/lgip_pkg.sv =====
// ----------------------------------------------------------------------------
// lgip_pkg: shared constants of the layered glyph-image parser
// Result kinds, status codes and field sizes used by the parser and its
// checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgip_pkg;

  // Result kinds.
  localparam logic KIND_CELL   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes. The "no layer count" code never arises, since any payload
  // too short to hold a layer count is reported as too small.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL   = 3'd1;
  localparam logic [2:0] ST_ZERO_LAYERS = 3'd3;
  localparam logic [2:0] ST_NO_WIDTH    = 3'd4;
  localparam logic [2:0] ST_NO_HEIGHT   = 3'd5;
  localparam logic [2:0] ST_BAD_DIMS    = 3'd6;
  localparam logic [2:0] ST_TRUNCATED   = 3'd7;

  // Field sizes in bytes.
  localparam logic [3:0] WORD_BYTES = 4'd4;
  localparam logic [3:0] CELL_BYTES = 4'd10;

endpackage

`default_nettype wire

// ===== rtl/layered_glyph_image_parser.sv =====
// Results are registered in the result queue and offered from its head.
// Throughput: one payload byte per cycle while input ready is high; a byte that
// completes a cell and ends the parse gives two results, which leave the four-entry result queue one at a time.
// Input ready is high while at least two queue entries are free.
// Reset (asynchronous, active low): parser returns to the header word phase,
// all counters clear and the result queue empties.
// ----------------------------------------------------------------------------
// layered_glyph_image_parser
// Streaming parser for a layered glyph-image payload, one byte per transfer,
// emitting one cell item per completed cell and a closing status item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module layered_glyph_image_parser #(
  parameter int OFFSET_BITS = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_payload_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [31:0]      layer_o,
  output logic [30:0]      column_o,
  output logic [30:0]      row_o,
  output logic [31:0]      glyph_o,
  output logic [23:0]      foreground_o,
  output logic [23:0]      background_o,
  output logic [2:0]       status_o,
  output logic [31:0]      format_version_o,
  output logic [47:0]      byte_offset_o,
  output logic             last_o
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_COUNT,
    PH_LEGACY_ZERO,
    PH_WIDTH,
    PH_HEIGHT,
    PH_CELL
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] layer;
    logic [30:0] column;
    logic [30:0] row;
    logic [31:0] glyph;
    logic [23:0] foreground;
    logic [23:0] background;
    logic [2:0]  status;
    logic [31:0] format_version;
    logic [47:0] byte_offset;
    logic        last;
  } res_t;

  // Parser state.
  phase_e                 phase_q, phase_d;
  logic [3:0]             bif_q, bif_d;
  logic [31:0]            word_q, word_d;
  logic [47:0]            colours_q, colours_d;
  logic [31:0]            layers_q, layers_d;
  logic [31:0]            layer_now_q, layer_now_d;
  logic [31:0]            width_q, width_d;
  logic [30:0]            height_q, height_d;
  logic [30:0]            col_q, col_d;
  logic [30:0]            row_q, row_d;
  logic [30:0]            max_w_q, max_w_d;
  logic [30:0]            max_h_q, max_h_d;
  logic [31:0]            version_q, version_d;
  logic [OFFSET_BITS-1:0] count_q, count_d;
  logic                   finished_q, finished_d;

  // Results of the current byte.
  logic                   in_fire;
  logic                   cell_emit;
  logic                   done;
  logic [2:0]             code;
  logic [OFFSET_BITS-1:0] off;
  res_t                   cell_res;
  res_t                   stat_res;

  // Result queue.
  res_t       queue_q [4];
  logic [1:0] wr_ptr_q;
  logic [1:0] rd_ptr_q;
  logic [2:0] fill_q;
  logic       out_fire;
  logic [1:0] push_n;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // Byte-by-byte parse step.
  always_comb begin
    logic [OFFSET_BITS-1:0] bc;
    logic [31:0]            byte_sh;
    logic [31:0]            w;
    logic [31:0]            row_inc;
    logic [31:0]            col_inc;
    logic [32:0]            layer_inc;
    logic [63:0]            off_wide;

    phase_d     = phase_q;
    bif_d       = bif_q;
    word_d      = word_q;
    colours_d   = colours_q;
    layers_d    = layers_q;
    layer_now_d = layer_now_q;
    width_d     = width_q;
    height_d    = height_q;
    col_d       = col_q;
    row_d       = row_q;
    max_w_d     = max_w_q;
    max_h_d     = max_h_q;
    version_d   = version_q;
    count_d     = count_q;
    finished_d  = finished_q;
    cell_emit   = 1'b0;
    done        = 1'b0;
    code        = lgip_pkg::ST_OK;
    off         = '0;
    cell_res    = '0;
    bc          = count_q;
    byte_sh     = 32'(data_byte_i) << {bif_q[1:0], 3'b000};
    w           = '0;
    row_inc     = {1'b0, row_q} + 32'd1;
    col_inc     = {1'b0, col_q} + 32'd1;
    layer_inc   = {1'b0, layer_now_q} + 33'd1;

    if (in_fire && !finished_q) begin
      // Saturating byte count.
      if (count_q != OFF_MAX) begin
        bc = count_q + OFFSET_BITS'(1);
      end
      count_d = bc;

      case (phase_q)
        PH_LEGACY_ZERO: begin
          if (bc == OFFSET_BITS'(8)) begin
            done = 1'b1;
            code = lgip_pkg::ST_ZERO_LAYERS;
            off  = OFFSET_BITS'(4);
          end
        end
        PH_CELL: begin
          // Glyph bytes little-endian, then six colour bytes in order.
          if (bif_q < lgip_pkg::WORD_BYTES) begin
            word_d = word_q | byte_sh;
          end else begin
            colours_d = {colours_q[39:0], data_byte_i};
          end
          bif_d = bif_q + 4'd1;
          if (bif_d == lgip_pkg::CELL_BYTES) begin
            cell_emit           = 1'b1;
            cell_res.kind       = lgip_pkg::KIND_CELL;
            cell_res.layer      = layer_now_q;
            cell_res.column     = col_q;
            cell_res.row        = row_q;
            cell_res.glyph      = word_d;
            cell_res.foreground = colours_d[47:24];
            cell_res.background = colours_d[23:0];
            bif_d     = '0;
            word_d    = '0;
            colours_d = '0;
            // Column-major walk: rows first, then columns, then layers.
            if (row_inc >= {1'b0, height_q}) begin
              row_d = '0;
              if (col_inc >= width_q) begin
                col_d = '0;
                if (width_q[30:0] > max_w_q) max_w_d = width_q[30:0];
                if (height_q > max_h_q) max_h_d = height_q;
                if (layer_inc >= {1'b0, layers_q}) begin
                  layer_now_d = layers_q;
                  done        = 1'b1;
                  code        = lgip_pkg::ST_OK;
                  off         = bc;
                end else begin
                  layer_now_d = layer_inc[31:0];
                  phase_d     = PH_WIDTH;
                end
              end else begin
                col_d = col_inc[30:0];
              end
            end else begin
              row_d = row_inc[30:0];
            end
          end
        end
        default: begin
          // Little-endian 32-bit words of the header and layer dimensions.
          word_d = word_q | byte_sh;
          bif_d  = bif_q + 4'd1;
          if (bif_d == lgip_pkg::WORD_BYTES) begin
            w      = word_d;
            bif_d  = '0;
            word_d = '0;
            case (phase_q)
              PH_HEADER: begin
                if (w[31]) begin
                  version_d = 32'd0 - w;
                  phase_d   = PH_COUNT;
                end else begin
                  version_d = '0;
                  layers_d  = w;
                  phase_d   = (w == 32'd0) ? PH_LEGACY_ZERO : PH_WIDTH;
                end
              end
              PH_COUNT: begin
                layers_d = w;
                if (w == 32'd0) begin
                  done = 1'b1;
                  code = lgip_pkg::ST_ZERO_LAYERS;
                  off  = bc;
                end else begin
                  phase_d = PH_WIDTH;
                end
              end
              PH_WIDTH: begin
                width_d = w;
                phase_d = PH_HEIGHT;
              end
              default: begin
                height_d = w[30:0];
                if (width_q == 32'd0 || width_q[31] || w == 32'd0 || w[31]) begin
                  done = 1'b1;
                  code = lgip_pkg::ST_BAD_DIMS;
                  off  = bc;
                end else begin
                  col_d   = '0;
                  row_d   = '0;
                  phase_d = PH_CELL;
                end
              end
            endcase
          end
        end
      endcase

      // End of payload before a natural finish.
      if (!done && end_of_payload_i) begin
        done = 1'b1;
        if (bc < OFFSET_BITS'(8)) begin
          code = lgip_pkg::ST_TOO_SMALL;
          off  = '0;
        end else begin
          if (phase_d == PH_HEIGHT) begin
            code = lgip_pkg::ST_NO_HEIGHT;
          end else if (phase_d == PH_CELL) begin
            code = lgip_pkg::ST_TRUNCATED;
          end else begin
            code = lgip_pkg::ST_NO_WIDTH;
          end
          off = (bc == OFF_MAX) ? bc : bc - OFFSET_BITS'(bif_d);
        end
      end

      if (done) begin
        finished_d = 1'b1;
      end
    end

    cell_res.last = !done;

    // Status item carries the values held after this byte.
    off_wide                = 64'(off);
    stat_res.kind           = lgip_pkg::KIND_STATUS;
    stat_res.layer          = layers_d;
    stat_res.column         = max_w_d;
    stat_res.row            = max_h_d;
    stat_res.glyph          = '0;
    stat_res.foreground     = '0;
    stat_res.background     = '0;
    stat_res.status         = code;
    stat_res.format_version = version_d;
    stat_res.byte_offset    = off_wide[47:0];
    stat_res.last           = 1'b1;

    // The final byte of a payload always re-arms the parser.
    if (in_fire && end_of_payload_i) begin
      phase_d     = PH_HEADER;
      bif_d       = '0;
      word_d      = '0;
      colours_d   = '0;
      layers_d    = '0;
      layer_now_d = '0;
      width_d     = '0;
      height_d    = '0;
      col_d       = '0;
      row_d       = '0;
      max_w_d     = '0;
      max_h_d     = '0;
      version_d   = '0;
      count_d     = '0;
      finished_d  = 1'b0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      bif_q       <= '0;
      word_q      <= '0;
      colours_q   <= '0;
      layers_q    <= '0;
      layer_now_q <= '0;
      width_q     <= '0;
      height_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      max_w_q     <= '0;
      max_h_q     <= '0;
      version_q   <= '0;
      count_q     <= '0;
      finished_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bif_q       <= bif_d;
      word_q      <= word_d;
      colours_q   <= colours_d;
      layers_q    <= layers_d;
      layer_now_q <= layer_now_d;
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      max_w_q     <= max_w_d;
      max_h_q     <= max_h_d;
      version_q   <= version_d;
      count_q     <= count_d;
      finished_q  <= finished_d;
    end
  end

  // Number of results written to the queue this cycle.
  assign push_n = {1'b0, cell_emit} + {1'b0, done};

  // Result queue storage: the first result at the write pointer, a status
  // that follows a cell in the next entry.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= cell_emit ? cell_res : stat_res;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + 2'd1] <= stat_res;
    end
  end

  // Result queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      fill_q <= fill_q + {1'b0, push_n} - {2'b00, out_fire};
    end
  end

  assign in_ready_o  = (fill_q <= 3'd2);
  assign out_valid_o = (fill_q != 3'd0);

  // Head of the queue drives the output ports.
  assign kind_o           = queue_q[rd_ptr_q].kind;
  assign layer_o          = queue_q[rd_ptr_q].layer;
  assign column_o         = queue_q[rd_ptr_q].column;
  assign row_o            = queue_q[rd_ptr_q].row;
  assign glyph_o          = queue_q[rd_ptr_q].glyph;
  assign foreground_o     = queue_q[rd_ptr_q].foreground;
  assign background_o     = queue_q[rd_ptr_q].background;
  assign status_o         = queue_q[rd_ptr_q].status;
  assign format_version_o = queue_q[rd_ptr_q].format_version;
  assign byte_offset_o    = queue_q[rd_ptr_q].byte_offset;
  assign last_o           = queue_q[rd_ptr_q].last;

endmodule

`default_nettype wire

// ===== rtl/lgip_checker.sv =====
// ----------------------------------------------------------------------------
// lgip_checker
// Port-level checks of the layered glyph-image parser, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgip_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        kind_o,
  input wire logic [31:0] glyph_o,
  input wire logic [23:0] foreground_o,
  input wire logic [23:0] background_o,
  input wire logic [2:0]  status_o,
  input wire logic [31:0] format_version_o,
  input wire logic [47:0] byte_offset_o,
  input wire logic        last_o
);

  // A stalled result keeps its valid, kind, last and status until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(kind_o) && $stable(last_o) && $stable(status_o))
    else $error("stalled result changed before its transfer");

  // A cell item carries no status information.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == lgip_pkg::KIND_CELL |->
      status_o == lgip_pkg::ST_OK && format_version_o == 32'd0 &&
      byte_offset_o == 48'd0)
    else $error("cell item carries status fields");

  // A status item always closes the results of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == lgip_pkg::KIND_STATUS |-> last_o)
    else $error("status item without last");

  // A status item carries no cell contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == lgip_pkg::KIND_STATUS |->
      glyph_o == 32'd0 && foreground_o == 24'd0 && background_o == 24'd0)
    else $error("status item carries cell contents");

endmodule

bind layered_glyph_image_parser lgip_checker u_lgip_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .kind_o           (kind_o),
  .glyph_o          (glyph_o),
  .foreground_o     (foreground_o),
  .background_o     (background_o),
  .status_o         (status_o),
  .format_version_o (format_version_o),
  .byte_offset_o    (byte_offset_o),
  .last_o           (last_o)
);

`default_nettype wire
